[hdl/rhp_pkg.sv]
// shared constants, control word type and arctangent table for the horizontal projection
package rhp_pkg;

    localparam int ITERATIONS_DEF = 18;
    localparam int RANGE_BITS_DEF = 16;

    localparam int ANGLE_W = 9;
    localparam int RANGE_W = 16;
    localparam int OUT_W   = 17;
    localparam int DEG_W   = 7;
    localparam int Z_W     = 19;
    localparam int XY_W    = 20;
    localparam int COS_W   = 17;

    localparam int ONE_Q16      = 65536;
    localparam int CORDIC_GAIN  = 39797;
    localparam int DEG_TO_RAD   = 74961321;
    localparam int ROUND_HALF   = 32768;
    localparam int HALF_TURN    = 180;
    localparam int QUARTER_TURN = 90;

    typedef struct packed {
        logic               valid;
        logic               zero_ang;
        logic               right_ang;
        logic               negative;
        logic [RANGE_W-1:0] range;
    } t_ctl;

    // round(atan(2^-i) * 2^16)
    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = Z_W'(51472);
            1:       v = Z_W'(30386);
            2:       v = Z_W'(16055);
            3:       v = Z_W'(8150);
            4:       v = Z_W'(4091);
            5:       v = Z_W'(2047);
            6:       v = Z_W'(1024);
            7:       v = Z_W'(512);
            8:       v = Z_W'(256);
            9:       v = Z_W'(128);
            10:      v = Z_W'(64);
            11:      v = Z_W'(32);
            12:      v = Z_W'(16);
            13:      v = Z_W'(8);
            14:      v = Z_W'(4);
            15:      v = Z_W'(2);
            16:      v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/rhp_front.sv]
// input cell: angle limit, quadrant fold and degree to radian conversion
module rhp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [rhp_pkg::ANGLE_W-1:0]  i_angle_deg,
    input  logic        [rhp_pkg::RANGE_W-1:0]  i_range_cm,
    output rhp_pkg::t_ctl                       o_ctl,
    output logic signed [rhp_pkg::XY_W-1:0]     o_x,
    output logic signed [rhp_pkg::XY_W-1:0]     o_y,
    output logic signed [rhp_pkg::Z_W-1:0]      o_z
);
    import rhp_pkg::*;

    localparam int PROD_W = 35;

    logic signed [ANGLE_W-1:0] sat;
    logic signed [ANGLE_W-1:0] neg_sat;
    logic        [7:0]         abs_deg;
    logic        [DEG_W-1:0]   deg;
    logic                      fold;
    logic        [PROD_W-1:0]  prod;

    t_ctl                  r_ctl;
    logic signed [Z_W-1:0] r_z;
    t_ctl                  n_ctl;
    logic signed [Z_W-1:0] n_z;

    always_comb begin
        if (i_angle_deg < -ANGLE_W'(HALF_TURN)) begin
            sat = -ANGLE_W'(HALF_TURN);
        end else if (i_angle_deg > ANGLE_W'(HALF_TURN)) begin
            sat = ANGLE_W'(HALF_TURN);
        end else begin
            sat = i_angle_deg;
        end
        neg_sat = -sat;
        abs_deg = sat[ANGLE_W-1] ? neg_sat[7:0] : sat[7:0];
        fold    = abs_deg > 8'(QUARTER_TURN);
        deg     = fold ? DEG_W'(8'(HALF_TURN) - abs_deg) : abs_deg[DEG_W-1:0];
        // q32 radians per degree, rounded back to q16
        prod    = PROD_W'(deg) * PROD_W'(DEG_TO_RAD) + PROD_W'(ROUND_HALF);
        n_z     = prod[PROD_W-1:16];

        n_ctl.valid     = i_start;
        n_ctl.zero_ang  = deg == '0;
        n_ctl.right_ang = deg == DEG_W'(QUARTER_TURN);
        n_ctl.negative  = fold;
        n_ctl.range     = i_range_cm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_z <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_z   = r_z;
    assign o_x   = XY_W'(CORDIC_GAIN);
    assign o_y   = '0;

endmodule

[hdl/rhp_cordic_cell.sv]
// one rotation step of the cordic chain
module rhp_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rhp_pkg::t_ctl                    i_ctl,
    input  logic signed [rhp_pkg::XY_W-1:0]  i_x,
    input  logic signed [rhp_pkg::XY_W-1:0]  i_y,
    input  logic signed [rhp_pkg::Z_W-1:0]   i_z,
    output rhp_pkg::t_ctl                    o_ctl,
    output logic signed [rhp_pkg::XY_W-1:0]  o_x,
    output logic signed [rhp_pkg::XY_W-1:0]  o_y,
    output logic signed [rhp_pkg::Z_W-1:0]   o_z
);
    import rhp_pkg::*;

    localparam logic signed [Z_W-1:0] ANGLE_STEP = atan_q16(IDX);

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [XY_W-1:0] n_x;
    logic signed [XY_W-1:0] n_y;
    logic signed [Z_W-1:0]  n_z;

    t_ctl                   r_ctl;
    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;

    always_comb begin
        xs = i_x >>> IDX;
        ys = i_y >>> IDX;
        if (!i_z[Z_W-1]) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ANGLE_STEP;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ANGLE_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

[hdl/rhp_back.sv]
// output cells: cosine clamp, range multiply and sign fix
module rhp_back #(
    parameter int RANGE_BITS = rhp_pkg::RANGE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rhp_pkg::t_ctl                    i_ctl,
    input  logic signed [rhp_pkg::XY_W-1:0]  i_x,
    output logic                             o_valid,
    output logic signed [rhp_pkg::OUT_W-1:0] o_horizontal_cm
);
    import rhp_pkg::*;

    localparam int RW     = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;
    localparam int PROD_W = RW + COS_W;

    logic [COS_W-1:0]  n_cos;
    logic [PROD_W-1:0] prod;
    logic [OUT_W-1:0]  mag_ext;

    t_ctl              r_ctl;
    logic [COS_W-1:0]  r_cos;
    logic              r_mag_valid;
    logic              r_mag_neg;
    logic [RW:0]       r_mag;
    logic              r_valid;
    logic [OUT_W-1:0]  r_out;

    always_comb begin
        if (i_ctl.zero_ang) begin
            n_cos = COS_W'(ONE_Q16);
        end else if (i_ctl.right_ang || i_x[XY_W-1]) begin
            n_cos = '0;
        end else if (i_x > XY_W'(ONE_Q16)) begin
            n_cos = COS_W'(ONE_Q16);
        end else begin
            n_cos = i_x[COS_W-1:0];
        end
        prod    = PROD_W'(r_ctl.range[RW-1:0]) * PROD_W'(r_cos);
        mag_ext = OUT_W'(r_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '0;
            r_mag_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_ctl       <= i_ctl;
            r_mag_valid <= r_ctl.valid;
            r_valid     <= r_mag_valid;
        end
        r_cos     <= n_cos;
        r_mag_neg <= r_ctl.negative;
        r_mag     <= prod[PROD_W-1:16];
        r_out     <= r_mag_neg ? -mag_ext : mag_ext;
    end

    assign o_valid         = r_valid;
    assign o_horizontal_cm = r_out;

endmodule

[hdl/range_horizontal_projection.sv]
// top level: horizontal component of a range reading, range times cosine of tilt
//
// Input channel: a word (i_angle_deg, i_range_cm) is taken at a rising edge with
// start high and busy low. busy stays low, so a word may be given every cycle.
// Output channel: o_horizontal_cm is shown for exactly one cycle with o_valid
// high; the receiver has no way to hold it off and must take it then.
// Each word is registered in the angle fold and radian conversion cell, then
// in each cordic cell of the rotation chain, then in the cosine clamp, the
// range multiply and the sign fix.
// Throughput is one word per cycle; every cell of the chain takes a new word
// each clock, so the figure is set by the chain advancing every cycle.
// Results leave in the order the words came in.
// Reset (synchronous, active low) clears every valid flag in the chain: words
// in flight are dropped and no result follows until new words are taken.
// Only the low RANGE_BITS bits of the range are used.
module range_horizontal_projection #(
    parameter int ITERATIONS = rhp_pkg::ITERATIONS_DEF,
    parameter int RANGE_BITS = rhp_pkg::RANGE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [rhp_pkg::ANGLE_W-1:0] i_angle_deg,
    input  logic        [rhp_pkg::RANGE_W-1:0] i_range_cm,
    output logic                               o_valid,
    output logic signed [rhp_pkg::OUT_W-1:0]   o_horizontal_cm
);
    import rhp_pkg::*;

    localparam int LATENCY = ITERATIONS + 4;

    t_ctl                   chain_ctl [ITERATIONS+1];
    logic signed [XY_W-1:0] chain_x   [ITERATIONS+1];
    logic signed [XY_W-1:0] chain_y   [ITERATIONS+1];
    logic signed [Z_W-1:0]  chain_z   [ITERATIONS+1];

    assign busy = 1'b0;

    rhp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_angle_deg (i_angle_deg),
        .i_range_cm  (i_range_cm),
        .o_ctl       (chain_ctl[0]),
        .o_x         (chain_x[0]),
        .o_y         (chain_y[0]),
        .o_z         (chain_z[0])
    );

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
        rhp_cordic_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (chain_ctl[g]),
            .i_x     (chain_x[g]),
            .i_y     (chain_y[g]),
            .i_z     (chain_z[g]),
            .o_ctl   (chain_ctl[g+1]),
            .o_x     (chain_x[g+1]),
            .o_y     (chain_y[g+1]),
            .o_z     (chain_z[g+1])
        );
    end

    rhp_back #(
        .RANGE_BITS (RANGE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (chain_ctl[ITERATIONS]),
        .i_x             (chain_x[ITERATIONS]),
        .o_valid         (o_valid),
        .o_horizontal_cm (o_horizontal_cm)
    );

    // every result traces back to an input word taken with start high
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without a matching input word");

    // a zero range gives zero whatever the angle
    a_zero_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_range_cm, LATENCY) == '0) |-> o_horizontal_cm == '0)
        else $error("non-zero result for zero range");

    // straight up or down has no horizontal component
    a_right_angle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_angle_deg, LATENCY) == ANGLE_W'(QUARTER_TURN) ||
                     $past(i_angle_deg, LATENCY) == -ANGLE_W'(QUARTER_TURN)))
        |-> o_horizontal_cm == '0)
        else $error("non-zero result at a right angle");

    // the magnitude stays below 2^16, so the result never takes the most negative value
    a_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_horizontal_cm != {1'b1, {(OUT_W-1){1'b0}}})
        else $error("result out of range");

endmodule
